[design/ipu_pkg.sv]
// Shared types, constants and register codes for the integer pixel upscaler.
`default_nettype none

package ipu_pkg;

    localparam int DEST_WIDTH  = 640;
    localparam int DEST_HEIGHT = 480;

    localparam int SCALE_W    = 2;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 9;
    localparam int PIX_W      = 8;
    localparam int ADDR_W     = 19;
    localparam int XPOS_W     = 13;
    localparam int YPOS_W     = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;
    localparam int TDATA_W    = 32;

    localparam logic [COL_W-1:0] WIDTH_RESET  = COL_W'(320);
    localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(240);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCALE  = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_index_t;

    typedef logic signed [XPOS_W-1:0] xpos_t;
    typedef logic signed [YPOS_W-1:0] ypos_t;

    // Effective configuration, with the out-of-range codes already folded.
    typedef struct packed {
        logic             scale2;
        logic [COL_W-1:0] width;
        logic [ROW_W-1:0] height;
        xpos_t            off_x;
        ypos_t            off_y;
    } cfg_t;

    typedef struct packed {
        logic       item_valid;
        logic       scale2;
        logic [1:0] sub;
    } gen_status_t;

endpackage

`default_nettype wire

[design/ipu_cfg.sv]
// Configuration registers and the centring offsets derived from them.
`default_nettype none

module ipu_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [ipu_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [ipu_pkg::CFG_DATA_W-1:0] wr_data,
    output ipu_pkg::cfg_t                       cfg
);
    import ipu_pkg::*;

    logic [SCALE_W-1:0] scale_reg;
    logic [COL_W-1:0]   width_reg;
    logic [ROW_W-1:0]   height_reg;

    logic               scale2;
    logic [COL_W-1:0]   width_eff;
    logic [ROW_W-1:0]   height_eff;
    logic [COL_W:0]     scaled_w;
    logic [ROW_W:0]     scaled_h;
    logic signed [12:0] diff_x;
    logic signed [11:0] diff_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg  <= SCALE_W'(1);
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_SCALE:  scale_reg  <= wr_data[SCALE_W-1:0];
                REG_WIDTH:  width_reg  <= wr_data[COL_W-1:0];
                REG_HEIGHT: height_reg <= wr_data[ROW_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        scale2     = scale_reg[1];
        width_eff  = (width_reg == '0) ? COL_W'(1) : width_reg;
        height_eff = (height_reg == '0) ? ROW_W'(1) : height_reg;
        scaled_w   = scale2 ? {width_eff, 1'b0} : {1'b0, width_eff};
        scaled_h   = scale2 ? {height_eff, 1'b0} : {1'b0, height_eff};
        diff_x     = 13'(DEST_WIDTH) - $signed({2'b00, scaled_w});
        diff_y     = 12'(DEST_HEIGHT) - $signed({2'b00, scaled_h});
        // The arithmetic shift rounds toward minus infinity, so a negative odd difference is nudged up first.
        cfg.scale2 = scale2;
        cfg.width  = width_eff;
        cfg.height = height_eff;
        cfg.off_x  = XPOS_W'($signed(diff_x + 13'(diff_x[12] & diff_x[0])) >>> 1);
        cfg.off_y  = YPOS_W'($signed(diff_y + 12'(diff_y[11] & diff_y[0])) >>> 1);
    end

endmodule

`default_nettype wire

[design/ipu_position.sv]
// Source column and row counters and the destination origin of the current pixel.
`default_nettype none

module ipu_position (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire ipu_pkg::cfg_t cfg,
    output ipu_pkg::xpos_t     base_x,
    output ipu_pkg::ypos_t     base_y
);
    import ipu_pkg::*;

    logic [COL_W-1:0] column_count_reg, column_count_next;
    logic [ROW_W-1:0] row_count_reg, row_count_next;
    logic [COL_W-1:0] col_inc;
    logic [ROW_W-1:0] row_inc;
    logic [COL_W:0]   col_scaled;
    logic [ROW_W:0]   row_scaled;

    always_comb
    begin
        col_inc           = column_count_reg + COL_W'(1);
        row_inc           = row_count_reg + ROW_W'(1);
        column_count_next = col_inc;
        row_count_next    = row_count_reg;
        // Also wraps counters left beyond a size that has just been lowered.
        if ((col_inc >= cfg.width) || (col_inc == '0))
        begin
            column_count_next = '0;
            row_count_next    = (row_inc >= cfg.height) ? '0 : row_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
        end
        else if (advance)
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
        end
    end

    always_comb
    begin
        col_scaled = cfg.scale2 ? {column_count_reg, 1'b0} : {1'b0, column_count_reg};
        row_scaled = cfg.scale2 ? {row_count_reg, 1'b0} : {1'b0, row_count_reg};
        base_x     = $signed({2'b00, col_scaled}) + cfg.off_x;
        base_y     = $signed({2'b00, row_scaled}) + cfg.off_y;
    end

endmodule

`default_nettype wire

[design/ipu_write_gen.sv]
// Item register, write sequencer, address generation and output register.
`default_nettype none

module ipu_write_gen (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [ipu_pkg::PIX_W-1:0] in_pixel,
    input  wire ipu_pkg::xpos_t            in_base_x,
    input  wire ipu_pkg::ypos_t            in_base_y,
    input  wire logic                      in_scale2,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [ipu_pkg::ADDR_W-1:0]     out_address,
    output logic [ipu_pkg::PIX_W-1:0]      out_pixel,
    output logic                           out_off_screen,
    output logic                           out_last,
    output ipu_pkg::gen_status_t           status
);
    import ipu_pkg::*;

    logic             item_valid_reg;
    logic [1:0]       sub_reg;
    logic             scale2_reg;
    logic [PIX_W-1:0] pixel_reg;
    xpos_t            base_x_reg;
    ypos_t            base_y_reg;

    logic              out_valid_reg;
    logic [ADDR_W-1:0] address_reg;
    logic [PIX_W-1:0]  out_pixel_reg;
    logic              off_screen_reg;
    logic              last_reg;

    logic              out_free;
    logic              gen_fire;
    logic              sub_last;
    logic              in_fire;
    xpos_t             pos_x;
    ypos_t             pos_y;
    logic              off;
    logic [ADDR_W-1:0] address_next;

    always_comb
    begin
        out_free = !out_valid_reg || out_ready;
        sub_last = scale2_reg ? (sub_reg == 2'd3) : (sub_reg == 2'd0);
        gen_fire = item_valid_reg && out_free;
        in_ready = !item_valid_reg || (out_free && sub_last);
        in_fire  = in_valid && in_ready;

        // Sub index: high bit picks the lower destination row, low bit the right column.
        pos_x = base_x_reg + XPOS_W'(sub_reg[0]);
        pos_y = base_y_reg + YPOS_W'(sub_reg[1]);
        off   = pos_x[XPOS_W-1] || (pos_x >= XPOS_W'(DEST_WIDTH)) ||
                pos_y[YPOS_W-1] || (pos_y >= YPOS_W'(DEST_HEIGHT));
        address_next = off ? '0 :
                       ADDR_W'(pos_y[9:0]) * ADDR_W'(DEST_WIDTH) + ADDR_W'(pos_x[9:0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            sub_reg        <= 2'd0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                item_valid_reg <= 1'b1;
                sub_reg        <= 2'd0;
            end
            else if (gen_fire)
            begin
                if (sub_last)
                begin
                    item_valid_reg <= 1'b0;
                    sub_reg        <= 2'd0;
                end
                else
                begin
                    sub_reg <= sub_reg + 2'd1;
                end
            end

            if (gen_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            scale2_reg <= in_scale2;
            pixel_reg  <= in_pixel;
            base_x_reg <= in_base_x;
            base_y_reg <= in_base_y;
        end
        if (gen_fire)
        begin
            address_reg    <= address_next;
            out_pixel_reg  <= pixel_reg;
            off_screen_reg <= off;
            last_reg       <= sub_last;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_address       = address_reg;
    assign out_pixel         = out_pixel_reg;
    assign out_off_screen    = off_screen_reg;
    assign out_last          = last_reg;
    assign status.item_valid = item_valid_reg;
    assign status.scale2     = scale2_reg;
    assign status.sub        = sub_reg;

endmodule

`default_nettype wire

[design/integer_pixel_upscaler_core.sv]
// Integer pixel upscaler: turns source pixels into centred frame-buffer write commands.
// Path: the first write of a pixel passes the item register, then the output register.
// Throughput, while m_axis_tready holds: one write per cycle on the output; one pixel per
// cycle at scale one and four writes per pixel at scale two, set by the single output write port.
// Reset: asynchronous, active low; clears counters, valids and sets the registers to
// scale one, 320 by 240. No memory and no clearing pass.
`default_nettype none

module integer_pixel_upscaler_core (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [7:0]                          s_axis_tdata,  // [7:0] src_pixel
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [18:0] dest_address, [26:19] out_pixel, [31:27] zero
    output logic [ipu_pkg::TDATA_W-1:0]              m_axis_tdata,
    output logic                                     m_axis_tuser,  // [0] off_screen
    output logic                                     m_axis_tlast,  // last_write
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [ipu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [ipu_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ipu_pkg::*;

    cfg_t              cfg;
    xpos_t             base_x;
    ypos_t             base_y;
    gen_status_t       status;
    logic [ADDR_W-1:0] address;
    logic [PIX_W-1:0]  pixel;
    logic              in_fire;

    assign cfg_ready = 1'b1;
    assign in_fire   = s_axis_tvalid && s_axis_tready;

    ipu_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ipu_position u_position (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (in_fire),
        .cfg     (cfg),
        .base_x  (base_x),
        .base_y  (base_y)
    );

    ipu_write_gen u_write_gen (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .in_pixel       (s_axis_tdata),
        .in_base_x      (base_x),
        .in_base_y      (base_y),
        .in_scale2      (cfg.scale2),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_address    (address),
        .out_pixel      (pixel),
        .out_off_screen (m_axis_tuser),
        .out_last       (m_axis_tlast),
        .status         (status)
    );

    assign m_axis_tdata = {(TDATA_W - ADDR_W - PIX_W)'(0), pixel, address};

    // A suppressed write carries a zero address.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[ADDR_W-1:0] == '0))
        else $error("off-screen write with non-zero address");

    // At scale one every pixel is a single write, so the sequencer never leaves step zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.item_valid && !status.scale2 |-> (status.sub == 2'd0))
        else $error("write sequencer stepped at scale one");

    // A newly taken pixel starts its writes from the first step.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> status.item_valid && (status.sub == 2'd0))
        else $error("accepted pixel did not start at the first write");

    // A pixel is only taken when no earlier pixel is mid-sequence.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && status.item_valid |-> (m_axis_tready || !m_axis_tvalid) &&
            (status.scale2 ? (status.sub == 2'd3) : (status.sub == 2'd0)))
        else $error("pixel accepted while writes were still pending");

endmodule

`default_nettype wire
